// ===== sv/epq_pkg.sv =====
package epq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_POP      = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [63:0] ev_time;
    logic [63:0] ev_seq;
    logic [1:0]  ev_kind;
    logic [31:0] ev_job;
    logic [31:0] ev_node;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage

// ===== sv/event_priority_queue_top.sv =====
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready  | opcode, event time, kind, job, node
// out_     | output    | out_valid / out_ready| status, time, sequence, kind, job, node, count
//
// One item per cycle while out_ready keeps up: the sorted cell row and the output register
// are both loaded at the clock edge that ends the transfer.
// Throughput limit is the output register: in_ready drops only while a result is held.
// rst_n (synchronous, active low) clears the count, the sequence stamp and out_valid;
// cell contents are not reset and are only read below the count.
// A stall on out_ready holds the result and blocks input until it is taken.
module event_priority_queue_top import epq_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_opcode,
  input  logic [63:0]      in_event_time,
  input  logic [1:0]       in_event_kind,
  input  logic [31:0]      in_job_number,
  input  logic [31:0]      in_node_number,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_time,
  output logic [63:0]      out_sequence,
  output logic [1:0]       out_kind,
  output logic [31:0]      out_job,
  output logic [31:0]      out_node,
  output logic [CNT_W-1:0] out_held_count
);

  // queue control
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [63:0]      seq_r, seq_nxt;

  // output register
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  entry_t           res_r, res_nxt;
  logic [CNT_W-1:0] held_r;

  logic      xfer;
  logic      is_pop;
  logic      full;
  logic      empty;
  cell_ctl_t ctl;
  entry_t    new_entry;

  // cell row: index 0 is the earliest event
  entry_t                 cell_q   [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] before_v;
  logic [QUEUE_DEPTH-1:0] occ_v;

  assign in_ready = !out_valid_r || out_ready;
  assign xfer     = in_valid && in_ready;
  assign is_pop   = (in_opcode == OP_POP);
  assign full     = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  assign ctl.ins = xfer && !is_pop && !full;
  assign ctl.pop = xfer && is_pop && !empty;

  assign new_entry.ev_time = in_event_time;
  assign new_entry.ev_seq  = seq_r;
  assign new_entry.ev_kind = in_event_kind;
  assign new_entry.ev_job  = in_job_number;
  assign new_entry.ev_node = in_node_number;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_b;

    assign occ_v[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign left_e = new_entry;
      assign left_b = 1'b0;
    end else begin : g_mid
      assign left_e = cell_q[i-1];
      assign left_b = before_v[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_tail
      assign right_e = cell_q[i];
    end else begin : g_body
      assign right_e = cell_q[i+1];
    end

    epq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ_v[i]),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_before (left_b),
      .right_entry (right_e),
      .entry_q     (cell_q[i]),
      .new_before  (before_v[i])
    );
  end

  always_comb begin
    count_nxt = count_r;
    seq_nxt   = seq_r;
    if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
      seq_nxt   = seq_r + 64'd1;
    end else if (ctl.pop) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      seq_r   <= seq_nxt;
      if (xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload: head entry on a pop, fresh stamp on a schedule, zeros on errors
  always_comb begin
    res_nxt    = '0;
    status_nxt = ST_OK;
    if (is_pop) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        res_nxt = cell_q[0];
      end
    end else begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        res_nxt.ev_seq = seq_r;
      end
    end
  end

  // result register, loaded on each input transfer
  always_ff @(posedge clk) begin
    if (xfer) begin
      held_r   <= count_nxt;
      res_r    <= res_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = status_r;
  assign out_time       = res_r.ev_time;
  assign out_sequence   = res_r.ev_seq;
  assign out_kind       = res_r.ev_kind;
  assign out_job        = res_r.ev_job;
  assign out_node       = res_r.ev_node;
  assign out_held_count = held_r;

endmodule

// ===== sv/epq_cell.sv =====
module epq_cell import epq_pkg::*; (
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_before,
  input  entry_t    right_entry,
  output entry_t    entry_q,
  output logic      new_before
);

  entry_t entry_r;
  entry_t entry_nxt;

  // new item ranks ahead of this cell: cell empty, earlier time, or same time and lower stamp
  assign new_before = !occupied ||
                      (new_entry.ev_time < entry_r.ev_time) ||
                      ((new_entry.ev_time == entry_r.ev_time) &&
                       (new_entry.ev_seq < entry_r.ev_seq));

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.pop) begin
      entry_nxt = right_entry;
    end else if (ctl.ins && new_before) begin
      entry_nxt = left_before ? left_entry : new_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry_q = entry_r;

endmodule

// ===== sv/epq_checker.sv =====
module epq_checker import epq_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             in_opcode,
  input logic [63:0]      in_event_time,
  input logic [1:0]       in_event_kind,
  input logic [31:0]      in_job_number,
  input logic [31:0]      in_node_number,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input logic [63:0]      out_time,
  input logic [63:0]      out_sequence,
  input logic [1:0]       out_kind,
  input logic [31:0]      out_job,
  input logic [31:0]      out_node,
  input logic [CNT_W-1:0] out_held_count
);

  // stalled result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_held_count) &&
                                $stable(out_sequence))
    else $error("result changed under stall");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_EMPTY) |-> (out_held_count == '0))
    else $error("empty pop with nonzero count");

  a_full_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_held_count == CNT_W'(QUEUE_DEPTH)))
    else $error("full reject below capacity");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |->
      (out_time == '0) && (out_sequence == '0) && (out_job == '0) && (out_node == '0))
    else $error("error result carries payload");

endmodule

bind event_priority_queue_top epq_checker u_epq_checker (.*);

// ===== tb/event_priority_queue_top_tb.sv =====
module event_priority_queue_top_tb;
  import epq_pkg::*;

  localparam int RANDOM_ITEMS = 950;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int REPORT_MAX   = 10;
  localparam int DRAIN_CYCLES = 10;

  // one command as presented on the in_ channel
  typedef struct {
    logic        opcode;
    logic [63:0] ev_time;
    logic [1:0]  kind;
    logic [31:0] job;
    logic [31:0] node;
  } queue_cmd_t;

  // one result as seen on the out_ channel
  typedef struct {
    status_t          status;
    logic [63:0]      ev_time;
    logic [63:0]      seq;
    logic [1:0]       kind;
    logic [31:0]      job;
    logic [31:0]      node;
    logic [CNT_W-1:0] held;
  } queue_reply_t;

  logic             clk            = 1'b0;
  logic             rst_n          = 1'b0;
  logic             in_valid       = 1'b0;
  logic             in_ready;
  logic             in_opcode      = OP_SCHEDULE;
  logic [63:0]      in_event_time  = '0;
  logic [1:0]       in_event_kind  = '0;
  logic [31:0]      in_job_number  = '0;
  logic [31:0]      in_node_number = '0;
  logic             out_valid;
  logic             out_ready      = 1'b0;
  logic [1:0]       out_status;
  logic [63:0]      out_time;
  logic [63:0]      out_sequence;
  logic [1:0]       out_kind;
  logic [31:0]      out_job;
  logic [31:0]      out_node;
  logic [CNT_W-1:0] out_held_count;

  // stimulus and scoreboard state
  queue_cmd_t   cmd_q[$];
  queue_reply_t awaited_results[$];
  queue_cmd_t   cur_cmd;
  int           total_cmds;
  int           accepted_cmds  = 0;
  int           mismatch_count = 0;
  int           cycle_count    = 0;
  int           gen_held       = 0;   // occupancy as the generator tracks it
  int           directed_cmds;

  // shadow of the queue contents, used only by the predictor
  entry_t       held_events[$];
  logic [63:0]  stamp_next = '0;

  // driver / monitor pacing
  int           in_gap   = 0;
  bit           in_calm  = 1'b0;
  logic         in_vld_nx;
  int           out_gap  = 0;
  bit           out_calm = 1'b1;
  logic         out_rdy_nx;
  queue_reply_t want;

  event_priority_queue_top u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_event_time  (in_event_time),
    .in_event_kind  (in_event_kind),
    .in_job_number  (in_job_number),
    .in_node_number (in_node_number),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_time       (out_time),
    .out_sequence   (out_sequence),
    .out_kind       (out_kind),
    .out_job        (out_job),
    .out_node       (out_node),
    .out_held_count (out_held_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predicted result of one accepted command. Schedules stamp and store; pops take the
  // earliest time, oldest stamp on a tie. Full schedules and empty pops return zeros.
  function automatic queue_reply_t apply_queue_op(queue_cmd_t c);
    queue_reply_t r;
    entry_t       e;
    int           best;
    r.status  = ST_OK;
    r.ev_time = '0;
    r.seq     = '0;
    r.kind    = '0;
    r.job     = '0;
    r.node    = '0;
    if (c.opcode == OP_SCHEDULE) begin
      if (held_events.size() >= QUEUE_DEPTH) begin
        r.status = ST_FULL;   // rejected, no stamp consumed
      end else begin
        e.ev_time = c.ev_time;
        e.ev_seq  = stamp_next;
        e.ev_kind = c.kind;
        e.ev_job  = c.job;
        e.ev_node = c.node;
        held_events.insert(held_events.size(), e);
        r.seq      = stamp_next;
        stamp_next = stamp_next + 64'd1;
      end
    end else if (held_events.size() == 0) begin
      r.status = ST_EMPTY;
    end else begin
      best = 0;
      for (int i = 1; i < held_events.size(); i++) begin
        if (held_events[i].ev_time < held_events[best].ev_time ||
            (held_events[i].ev_time == held_events[best].ev_time &&
             held_events[i].ev_seq < held_events[best].ev_seq))
          best = i;
      end
      e         = held_events[best];
      r.ev_time = e.ev_time;
      r.seq     = e.ev_seq;
      r.kind    = e.ev_kind;
      r.job     = e.ev_job;
      r.node    = e.ev_node;
      held_events.delete(best);
    end
    r.held = CNT_W'(held_events.size());
    return r;
  endfunction

  // Times lean toward a handful of small values so that ties are common.
  function automatic logic [63:0] pick_time();
    case ($urandom_range(0, 7))
      0, 1, 2: return 64'($urandom_range(0, 7));
      3:       return 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
      4:       return {$urandom, 32'h0};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [31:0] pick_id();
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(logic op, logic [63:0] t, logic [1:0] k, logic [31:0] j,
                         logic [31:0] n);
    queue_cmd_t c;
    c.opcode  = op;
    c.ev_time = t;
    c.kind    = k;
    c.job     = j;
    c.node    = n;
    cmd_q.insert(cmd_q.size(), c);
    if (op == OP_SCHEDULE) begin
      if (gen_held < QUEUE_DEPTH) gen_held++;
    end else if (gen_held > 0) begin
      gen_held--;
    end
  endtask

  task automatic add_random_schedule();
    add_cmd(OP_SCHEDULE, pick_time(), 2'($urandom_range(0, 3)), pick_id(), pick_id());
  endtask

  // payload of a pop is ignored by the block but still toggled
  task automatic add_random_pop();
    add_cmd(OP_POP, {$urandom, $urandom}, 2'($urandom), $urandom, $urandom);
  endtask

  // Driver: one transfer per handshake, then a random hold-off before the next command.
  // Valid is computed into in_vld_nx so that it gets exactly one update per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      in_vld_nx = in_valid;
      if (in_valid && in_ready) begin
        awaited_results.insert(awaited_results.size(), apply_queue_op(cur_cmd));
        accepted_cmds++;
        in_vld_nx = 1'b0;
        if ($urandom_range(0, 15) == 0) in_calm = !in_calm;
        in_gap = in_calm ? 0 : $urandom_range(0, 14);
      end
      if (!in_vld_nx) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (cmd_q.size() != 0) begin
          cur_cmd         = cmd_q.pop_front();
          in_opcode      <= cur_cmd.opcode;
          in_event_time  <= cur_cmd.ev_time;
          in_event_kind  <= cur_cmd.kind;
          in_job_number  <= cur_cmd.job;
          in_node_number <= cur_cmd.node;
          in_vld_nx       = 1'b1;
        end
      end
      in_valid <= in_vld_nx;
    end
  end

  // Monitor: checks each result transfer against the oldest prediction, then may hold
  // out_ready low for a random gap.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_rdy_nx = out_ready;
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result: status=%0d seq=%h held=%0d",
                     out_status, out_sequence, out_held_count);
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_time !== want.ev_time ||
              out_sequence !== want.seq || out_kind !== want.kind ||
              out_job !== want.job || out_node !== want.node ||
              out_held_count !== want.held) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX) begin
              $display("mismatch exp: status=%0d time=%h seq=%h kind=%0d job=%h node=%h held=%0d",
                       want.status, want.ev_time, want.seq, want.kind, want.job,
                       want.node, want.held);
              $display("         act: status=%0d time=%h seq=%h kind=%0d job=%h node=%h held=%0d",
                       out_status, out_time, out_sequence, out_kind, out_job,
                       out_node, out_held_count);
            end
          end
        end
        out_rdy_nx = 1'b0;
        if ($urandom_range(0, 15) == 0) out_calm = !out_calm;
        out_gap = out_calm ? 0 : $urandom_range(0, 14);
      end
      if (!out_rdy_nx) begin
        if (out_gap > 0) out_gap--;
        else out_rdy_nx = 1'b1;
      end
      out_ready <= out_rdy_nx;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    // directed: empty pop, field extremes, all four kinds, equal-time ties, drain past empty
    add_cmd(OP_POP, '0, '0, '0, '0);
    add_cmd(OP_SCHEDULE, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_cmd(OP_SCHEDULE, 64'h0, 2'd0, 32'h0, 32'h0);
    add_cmd(OP_SCHEDULE, 64'd5, 2'd1, 32'h1234_5678, 32'h0000_0001);
    add_cmd(OP_SCHEDULE, 64'd5, 2'd2, 32'h0000_0002, 32'h8000_0000);
    add_cmd(OP_SCHEDULE, 64'd5, 2'd3, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    repeat (6) add_cmd(OP_POP, '0, '0, '0, '0);
    add_cmd(OP_SCHEDULE, 64'h8000_0000_0000_0000, 2'd0, 32'h8000_0000, 32'h7FFF_FFFF);
    add_cmd(OP_SCHEDULE, 64'h7FFF_FFFF_FFFF_FFFF, 2'd1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_cmd(OP_SCHEDULE, 64'h7FFF_FFFF_FFFF_FFFF, 2'd2, 32'h0, 32'hFFFF_FFFF);
    add_cmd(OP_POP, 64'hFFFF_FFFF_FFFF_FFFF, 2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    repeat (3) add_cmd(OP_POP, '0, '0, '0, '0);
    directed_cmds = cmd_q.size();

    // random: fill-to-full runs that push past the limit, drain-to-empty runs that pop
    // past zero, and mixed stretches in between
    while (cmd_q.size() < directed_cmds + RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin
          while (gen_held < QUEUE_DEPTH) begin
            if ($urandom_range(0, 9) == 0) add_random_pop();
            else add_random_schedule();
          end
          repeat ($urandom_range(1, 4)) add_random_schedule();
        end
        1: begin
          while (gen_held > 0) begin
            if ($urandom_range(0, 9) == 0) add_random_schedule();
            else add_random_pop();
          end
          repeat ($urandom_range(1, 3)) add_random_pop();
        end
        default: begin
          repeat ($urandom_range(10, 80)) begin
            if ($urandom_range(0, 1) == 0) add_random_schedule();
            else add_random_pop();
          end
        end
      endcase
    end
    total_cmds = cmd_q.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // every command transferred and every prediction checked, then a short tail to
    // catch any stray result
    while (accepted_cmds < total_cmds || awaited_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/epq_pkg.sv
sv/epq_cell.sv
sv/event_priority_queue_top.sv
sv/epq_checker.sv
tb/event_priority_queue_top_tb.sv
